@@ hdl/sha256_pkg.sv @@
// Shared types, constants and helpers for the SHA-256 stream hasher.
// No dependencies; compiled first.
package sha256_pkg;

  // Field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned INDEX_W = 3;

  // Input function codes (code 3 carries no meaning and is ignored)
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ABSORB        = 2'd0,
    FUNC_ABSORB_FINISH = 2'd1,
    FUNC_FINISH        = 2'd2
  } func_e;

  // Source of the byte shifted into the block buffer
  typedef enum logic [1:0] {
    BYTE_DATA  = 2'd0,
    BYTE_PAD80 = 2'd1,
    BYTE_ZERO  = 2'd2,
    BYTE_LEN   = 2'd3
  } byte_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;        // shift one byte into the block buffer
    byte_sel_e byte_sel;
    logic      count_bits;  // byte is message data: add 8 to the bit length
    logic      start;       // load working vars from hash, clear round counter
    logic      step;        // one compression round
    logic      hash_add;    // fold working vars into the hash words
    logic      emit_next;   // digest word taken, advance word index
    logic      msg_reset;   // back to initial hash, empty message
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_last;   // 63 bytes held: next load completes the block
    logic fill_at56;   // length field starts here
    logic rnd_last;    // round 63 in progress
    logic emit_last;   // word index 7 on the output
  } dp_sts_t;

  localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Rotate right by a constant amount
  function automatic logic [WORD_W-1:0] ror32(logic [WORD_W-1:0] x, int unsigned n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

endpackage

@@ hdl/sha256_if.sv @@
// Valid/ready channel interfaces for the hasher's byte input and digest output.
// Depends on sha256_pkg for field widths.

interface sha256_in_if;
  logic                             valid;
  logic                             ready;
  logic [sha256_pkg::FUNC_W-1:0]    func;
  logic [sha256_pkg::BYTE_W-1:0]    data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface sha256_out_if;
  logic                             valid;
  logic                             ready;
  logic [sha256_pkg::WORD_W-1:0]    digest_word;
  logic [sha256_pkg::INDEX_W-1:0]   word_index;
  logic                             last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

@@ hdl/sha256_dp.sv @@
// SHA-256 datapath: block buffer / message schedule, round unit, hash words,
// fill and length counters, digest word select. Depends on sha256_pkg.
module sha256_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sha256_pkg::BYTE_W-1:0] data_byte_i,
  input  sha256_pkg::dp_cmd_t           cmd_i,
  output sha256_pkg::dp_sts_t           sts_o,
  output logic [sha256_pkg::WORD_W-1:0] digest_word_o,
  output logic [sha256_pkg::INDEX_W-1:0] word_index_o,
  output logic                          last_word_o
);
  import sha256_pkg::*;

  // Block buffer: word 0 in the top bits; doubles as the 16-word schedule window
  logic [511:0]        blk_q, blk_d;
  logic [WORD_W-1:0]   v_q [8];
  logic [WORD_W-1:0]   v_d [8];
  logic [WORD_W-1:0]   hash_q [8];
  logic [WORD_W-1:0]   hash_d [8];
  logic [5:0]          fill_q, fill_d;
  logic [63:0]         bits_q, bits_d;
  logic [5:0]          rnd_q, rnd_d;
  logic [INDEX_W-1:0]  idx_q, idx_d;

  logic [BYTE_W-1:0]   len_bytes [8];
  logic [BYTE_W-1:0]   in_byte;
  logic [WORD_W-1:0]   w_t, w_1, w_9, w_14, sig0, sig1, new_w;
  logic [WORD_W-1:0]   bs0, bs1, ch, mj, t1, t2;

  // Length bytes, most significant first
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      len_bytes[i] = bits_q[63-8*i -: 8];
    end
  end

  always_comb begin
    case (cmd_i.byte_sel)
      BYTE_DATA:  in_byte = data_byte_i;
      BYTE_PAD80: in_byte = 8'h80;
      BYTE_ZERO:  in_byte = 8'h00;
      BYTE_LEN:   in_byte = len_bytes[fill_q[2:0]];
      default:    in_byte = 8'h00;
    endcase
  end

  // Message schedule: window holds w[t..t+15]
  always_comb begin
    w_t   = blk_q[511:480];
    w_1   = blk_q[479:448];
    w_9   = blk_q[223:192];
    w_14  = blk_q[63:32];
    sig0  = ror32(w_1, 7) ^ ror32(w_1, 18) ^ (w_1 >> 3);
    sig1  = ror32(w_14, 17) ^ ror32(w_14, 19) ^ (w_14 >> 10);
    new_w = sig1 + w_9 + sig0 + w_t;
  end

  // Round function
  always_comb begin
    bs1 = ror32(v_q[4], 6) ^ ror32(v_q[4], 11) ^ ror32(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + bs1 + ch + ROUND_K[rnd_q] + w_t;
    bs0 = ror32(v_q[0], 2) ^ ror32(v_q[0], 13) ^ ror32(v_q[0], 22);
    mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = bs0 + mj;
  end

  // Next-state logic
  always_comb begin
    blk_d  = blk_q;
    v_d    = v_q;
    hash_d = hash_q;
    fill_d = fill_q;
    bits_d = bits_q;
    rnd_d  = rnd_q;
    idx_d  = idx_q;

    if (cmd_i.load) begin
      blk_d  = {blk_q[503:0], in_byte};
      fill_d = fill_q + 6'd1;
    end else if (cmd_i.step) begin
      blk_d  = {blk_q[479:0], new_w};
    end

    if (cmd_i.load && cmd_i.count_bits) begin
      bits_d = bits_q + 64'd8;
    end

    if (cmd_i.start) begin
      v_d   = hash_q;
      rnd_d = '0;
    end else if (cmd_i.step) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      rnd_d  = rnd_q + 6'd1;
    end

    if (cmd_i.hash_add) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + v_q[i];
      end
    end

    if (cmd_i.emit_next) begin
      idx_d = idx_q + 3'd1;
    end

    if (cmd_i.msg_reset) begin
      hash_d = INIT_HASH;
      fill_d = '0;
      bits_d = '0;
      idx_d  = '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= INIT_HASH;
      fill_q <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      idx_q  <= '0;
    end else begin
      hash_q <= hash_d;
      fill_q <= fill_d;
      bits_q <= bits_d;
      rnd_q  <= rnd_d;
      idx_q  <= idx_d;
    end
  end

  // Payload: block buffer and working vars
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
  end

  // Status and digest output
  assign sts_o.fill_last = (fill_q == 6'd63);
  assign sts_o.fill_at56 = (fill_q == 6'd56);
  assign sts_o.rnd_last  = (rnd_q == 6'd63);
  assign sts_o.emit_last = (idx_q == 3'd7);

  assign digest_word_o = hash_q[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'd7);

endmodule

@@ hdl/sha256_ctrl.sv @@
// SHA-256 hasher controller: input/output handshakes, padding sequence,
// compression and digest output sequencing. Depends on sha256_pkg.
module sha256_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [sha256_pkg::FUNC_W-1:0] func_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sha256_pkg::dp_cmd_t           cmd_o,
  input  sha256_pkg::dp_sts_t           sts_i
);
  import sha256_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD80 = 7'b0000010,
    S_PADZ  = 7'b0000100,
    S_LEN   = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_FINAL = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  state_e cont_q, cont_d;   // where to go after the current compression

  // Shift one byte; on the 64th byte start a compression
  function automatic void load_byte(input byte_sel_e sel, input logic fill_last,
                                    input state_e after, inout dp_cmd_t cmd,
                                    inout state_e nxt, inout state_e cont);
    cmd.load     = 1'b1;
    cmd.byte_sel = sel;
    if (fill_last) begin
      cmd.start = 1'b1;
      nxt       = S_ROUND;
      cont      = after;
    end
  endfunction

  always_comb begin
    state_d     = state_q;
    cont_d      = cont_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_i)
            FUNC_ABSORB: begin
              cmd_o.count_bits = 1'b1;
              load_byte(BYTE_DATA, sts_i.fill_last, S_IDLE, cmd_o, state_d, cont_d);
            end
            FUNC_ABSORB_FINISH: begin
              cmd_o.count_bits = 1'b1;
              state_d = S_PAD80;
              load_byte(BYTE_DATA, sts_i.fill_last, S_PAD80, cmd_o, state_d, cont_d);
            end
            FUNC_FINISH: state_d = S_PAD80;
            default: ;
          endcase
        end
      end
      S_PAD80: begin
        state_d = S_PADZ;
        load_byte(BYTE_PAD80, sts_i.fill_last, S_PADZ, cmd_o, state_d, cont_d);
      end
      S_PADZ: begin
        if (sts_i.fill_at56) begin
          state_d = S_LEN;
        end else begin
          load_byte(BYTE_ZERO, sts_i.fill_last, S_PADZ, cmd_o, state_d, cont_d);
        end
      end
      S_LEN: begin
        load_byte(BYTE_LEN, sts_i.fill_last, S_EMIT, cmd_o, state_d, cont_d);
      end
      S_ROUND: begin
        cmd_o.step = 1'b1;
        if (sts_i.rnd_last) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd_o.hash_add = 1'b1;
        state_d        = cont_q;
      end
      S_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_next = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.msg_reset = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cont_q  <= S_IDLE;
    end else begin
      state_q <= state_d;
      cont_q  <= cont_d;
    end
  end

endmodule

@@ hdl/sha256_stream_hasher_unit.sv @@
// SHA-256 stream hasher: one message byte per input transfer, digest out as
// eight 32-bit words. The 64th byte of a block starts a compression: 64 rounds
// on one round unit plus the hash update. A finish shifts in padding and length
// one byte a cycle, pausing while a compression runs; it runs one or two
// compressions, then holds 8 output transfers. Input is taken only when idle.
// Reset (rst_ni low, asynchronous): initial hash values, empty message.
module sha256_stream_hasher_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  sha256_in_if.sink          in_i,
  sha256_out_if.source       out_o
);
  import sha256_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .func_i      (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  sha256_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (in_i.data_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

endmodule
